// ----- rtl/bmu_pkg.sv -----
// Shared constants for the breakpoint match unit: table size, function codes and action codes.
package bmu_pkg;

  // Number of breakpoint entries in the table.
  localparam int TABLE_DEPTH = 16;
  // Bits needed to address one entry.
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  // Bits needed to count from zero up to and including the depth.
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  // Width of a stored entry: script hash above pc.
  localparam int ENTRY_W = 64;

  // Function codes of an input transfer.
  localparam logic [2:0] FUNC_STEP       = 3'd0;
  localparam logic [2:0] FUNC_ADD        = 3'd1;
  localparam logic [2:0] FUNC_REMOVE     = 3'd2;
  localparam logic [2:0] FUNC_RESUME     = 3'd3;
  localparam logic [2:0] FUNC_REMOVE_ALL = 3'd4;

  // Whole-game action codes.
  localparam logic [1:0] GAME_NONE    = 2'd0;
  localparam logic [1:0] GAME_PAUSE   = 2'd1;
  localparam logic [1:0] GAME_UNPAUSE = 2'd2;

endpackage

// ----- rtl/bmu_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
module bmu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/breakpoint_match_unit_core.sv -----
// Top level of the breakpoint match unit: sequencer, table walk and result decision.
// Step, add and remove walk the table in SCAN, then pass DECIDE; the result strobe is registered from DECIDE.
// Resume, remove-all and unused codes skip the walk and go straight to DECIDE; busy is high until the strobe.
// The table walk reads one entry per cycle through the single RAM read port and one 64-bit comparator.
// The strobe lasts one cycle and cannot be stalled; a new transfer is not accepted while busy.
// Synchronous active-low reset clears all valid bits, the active breakpoint and the configuration.
module breakpoint_match_unit_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_func,
  input  logic [31:0] in_script_hash,
  input  logic [31:0] in_pc,
  input  logic        in_thread_exists,
  input  logic        in_thread_killed,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  output logic        out_valid,
  output logic        out_ok,
  output logic        out_table_full,
  output logic [1:0]  out_game_action,
  output logic        out_pause_thread,
  output logic        out_run_thread,
  output logic        out_active_valid,
  output logic [31:0] out_active_script,
  output logic [31:0] out_active_pc
);
  import bmu_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_DECIDE = 2'd2;

  logic [1:0]             state_r, state_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   cmp_pend_r, cmp_pend_nxt;
  logic [IDX_W-1:0]       cmp_idx_r, cmp_idx_nxt;
  logic                   found_r, found_nxt;
  logic [IDX_W-1:0]       found_idx_r, found_idx_nxt;
  logic                   free_ok_r, free_ok_nxt;
  logic [IDX_W-1:0]       free_idx_r, free_idx_nxt;

  logic [2:0]             func_r;
  logic [31:0]            script_r;
  logic [31:0]            pc_r;
  logic                   exists_r;
  logic                   killed_r;

  logic [TABLE_DEPTH-1:0] valid_r, valid_nxt;
  logic                   held_valid_r, held_valid_nxt;
  logic [31:0]            held_script_r, held_script_nxt;
  logic [31:0]            held_pc_r, held_pc_nxt;
  logic                   skip_r, skip_nxt;
  logic                   game_paused_r, game_paused_nxt;
  logic                   pause_game_cfg_r;

  logic                   out_valid_r;
  logic                   ok_r, ok_nxt;
  logic                   full_r, full_nxt;
  logic [1:0]             game_act_r, game_act_nxt;
  logic                   pth_r, pth_nxt;
  logic                   run_r, run_nxt;

  logic                   ram_we;
  logic [IDX_W-1:0]       ram_raddr;
  logic [ENTRY_W-1:0]     ram_rdata;
  logic                   entry_hit;
  logic                   accept;
  logic                   needs_scan;
  logic                   held_match;
  logic                   resume_ok;

  assign accept     = start && !busy;
  assign busy       = (state_r != ST_IDLE);
  assign needs_scan = (in_func == FUNC_STEP) || (in_func == FUNC_ADD) ||
                      (in_func == FUNC_REMOVE);

  // Breakpoint table storage: script hash in the upper half, pc in the lower.
  bmu_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (free_idx_r),
    .wdata ({script_r, pc_r}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign ram_raddr = cnt_r[IDX_W-1:0];
  assign ram_we    = (state_r == ST_DECIDE) && (func_r == FUNC_ADD) && !found_r && free_ok_r;

  // The shared comparator: one entry read last cycle against the captured pair.
  assign entry_hit = cmp_pend_r && valid_r[cmp_idx_r] && (ram_rdata == {script_r, pc_r});

  // Sequencer and table walk.
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cmp_pend_nxt  = 1'b0;
    cmp_idx_nxt   = cmp_idx_r;
    found_nxt     = found_r;
    found_idx_nxt = found_idx_r;
    free_ok_nxt   = free_ok_r;
    free_idx_nxt  = free_idx_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cnt_nxt     = '0;
          found_nxt   = 1'b0;
          free_ok_nxt = 1'b0;
          state_nxt   = needs_scan ? ST_SCAN : ST_DECIDE;
        end
      end
      ST_SCAN: begin
        // Issue the next read while the previous one is compared.
        if (cnt_r < CNT_W'(TABLE_DEPTH)) begin
          cmp_pend_nxt = 1'b1;
          cmp_idx_nxt  = cnt_r[IDX_W-1:0];
          cnt_nxt      = cnt_r + CNT_W'(1);
        end else if (!cmp_pend_r) begin
          state_nxt = ST_DECIDE;
        end
        if (entry_hit) begin
          found_nxt     = 1'b1;
          found_idx_nxt = cmp_idx_r;
        end
        // The lowest free entry is the first invalid one seen.
        if (cmp_pend_r && !valid_r[cmp_idx_r] && !free_ok_r) begin
          free_ok_nxt  = 1'b1;
          free_idx_nxt = cmp_idx_r;
        end
      end
      ST_DECIDE: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign held_match = held_valid_r && (held_script_r == script_r) && (held_pc_r == pc_r);
  assign resume_ok  = held_valid_r && exists_r;

  // Decision: state updates and result fields of one transfer.
  always_comb begin
    valid_nxt       = valid_r;
    held_valid_nxt  = held_valid_r;
    held_script_nxt = held_script_r;
    held_pc_nxt     = held_pc_r;
    skip_nxt        = skip_r;
    game_paused_nxt = game_paused_r;
    ok_nxt          = 1'b0;
    full_nxt        = 1'b0;
    game_act_nxt    = GAME_NONE;
    pth_nxt         = 1'b0;
    run_nxt         = 1'b0;
    if (state_r == ST_DECIDE) begin
      case (func_r)
        FUNC_STEP: begin
          // Drop the active breakpoint whose thread has gone away.
          if (held_valid_r && (!exists_r || killed_r)) begin
            skip_nxt        = 1'b0;
            held_valid_nxt  = 1'b0;
            held_script_nxt = '0;
            held_pc_nxt     = '0;
          end
          if (found_r) begin
            if (skip_nxt) begin
              skip_nxt = 1'b0;
            end else begin
              held_valid_nxt  = 1'b1;
              held_script_nxt = script_r;
              held_pc_nxt     = pc_r;
              ok_nxt          = 1'b1;
              if (pause_game_cfg_r) begin
                game_act_nxt    = GAME_PAUSE;
                game_paused_nxt = 1'b1;
              end else begin
                pth_nxt = 1'b1;
              end
            end
          end
        end
        FUNC_ADD: begin
          if (!found_r) begin
            if (!free_ok_r) begin
              full_nxt = 1'b1;
            end else begin
              valid_nxt[free_idx_r] = 1'b1;
              ok_nxt                = 1'b1;
            end
          end
        end
        FUNC_REMOVE, FUNC_RESUME, FUNC_REMOVE_ALL: begin
          // Resume of the active breakpoint, shared by three functions.
          if (((func_r == FUNC_REMOVE) && found_r && held_match && exists_r) ||
              ((func_r != FUNC_REMOVE) && resume_ok)) begin
            if (game_paused_r) begin
              game_act_nxt    = GAME_UNPAUSE;
              game_paused_nxt = 1'b0;
            end else begin
              run_nxt = 1'b1;
            end
            skip_nxt        = 1'b1;
            held_valid_nxt  = 1'b0;
            held_script_nxt = '0;
            held_pc_nxt     = '0;
          end
          if (func_r == FUNC_REMOVE) begin
            if (found_r) begin
              valid_nxt[found_idx_r] = 1'b0;
              ok_nxt                 = 1'b1;
            end
          end else begin
            ok_nxt = resume_ok;
          end
          if (func_r == FUNC_REMOVE_ALL) begin
            valid_nxt = '0;
          end
        end
        default: begin
          ok_nxt = 1'b0;
        end
      endcase
    end
  end

  // Control and architectural state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= ST_IDLE;
      cnt_r            <= '0;
      cmp_pend_r       <= 1'b0;
      found_r          <= 1'b0;
      free_ok_r        <= 1'b0;
      valid_r          <= '0;
      held_valid_r     <= 1'b0;
      held_script_r    <= '0;
      held_pc_r        <= '0;
      skip_r           <= 1'b0;
      game_paused_r    <= 1'b0;
      pause_game_cfg_r <= 1'b0;
      out_valid_r      <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      cnt_r         <= cnt_nxt;
      cmp_pend_r    <= cmp_pend_nxt;
      found_r       <= found_nxt;
      free_ok_r     <= free_ok_nxt;
      valid_r       <= valid_nxt;
      held_valid_r  <= held_valid_nxt;
      held_script_r <= held_script_nxt;
      held_pc_r     <= held_pc_nxt;
      skip_r        <= skip_nxt;
      game_paused_r <= game_paused_nxt;
      out_valid_r   <= (state_r == ST_DECIDE);
      if (cfg_we) begin
        pause_game_cfg_r <= cfg_wdata;
      end
    end
  end

  // Payload registers: captured transfer, walk indexes and result fields.
  always_ff @(posedge clk) begin
    cmp_idx_r   <= cmp_idx_nxt;
    found_idx_r <= found_idx_nxt;
    free_idx_r  <= free_idx_nxt;
    if (accept) begin
      func_r   <= in_func;
      script_r <= in_script_hash;
      pc_r     <= in_pc;
      exists_r <= in_thread_exists;
      killed_r <= in_thread_killed;
    end
    if (state_r == ST_DECIDE) begin
      ok_r       <= ok_nxt;
      full_r     <= full_nxt;
      game_act_r <= game_act_nxt;
      pth_r      <= pth_nxt;
      run_r      <= run_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_ok            = ok_r;
  assign out_table_full    = full_r;
  assign out_game_action   = game_act_r;
  assign out_pause_thread  = pth_r;
  assign out_run_thread    = run_r;
  assign out_active_valid  = held_valid_r;
  assign out_active_script = held_script_r;
  assign out_active_pc     = held_pc_r;

endmodule
